// ===== hdl/asc_pkg.sv =====
// Shared types and constants for the access stride classifier.
`timescale 1ns / 1ps
package asc_pkg;

    localparam int SITES    = 1024;
    localparam int SITE_W   = $clog2(SITES);
    localparam int QDEPTH   = 2;

    localparam logic [1:0] CLS_UNINIT = 2'd0;
    localparam logic [1:0] CLS_CONST  = 2'd1;
    localparam logic [1:0] CLS_LINEAR = 2'd2;
    localparam logic [1:0] CLS_RANDOM = 2'd3;

    localparam logic [1:0] PAT_CONST  = 2'd0;
    localparam logic [1:0] PAT_LINEAR = 2'd1;
    localparam logic [1:0] PAT_RANDOM = 2'd2;

    typedef struct packed {
        logic [SITE_W-1:0] site;
        logic [31:0]       iteration;
        logic [63:0]       address;
        logic [7:0]        nbytes;
        logic              wr;
    } req_t;

    typedef struct packed {
        logic [1:0]  pattern;
        logic        changed;
        logic [63:0] base;
        logic [31:0] stride;
        logic [31:0] biter;
        logic [31:0] count;
        logic [63:0] address;
        logic        mismatch;
    } res_t;

endpackage

// ===== hdl/access_stride_classifier_top.sv =====
// Top level of the access stride classifier.
//
// Channel  | Handshake         | Payload
// request  | in_valid/in_ready | site_index, iteration, access_address, access_bytes, is_write
// result   | out_valid/out_ready | pattern .. attribute_mismatch
//
// A request passes the queue, the table read and write back, which registers its result;
// the table engine takes a new request only after the last is written back. A linear
// site also passes a multiply state for the prediction, and a stride division runs in
// the bit-serial divider. A two-entry queue accepts requests while the engine works; a
// held result stalls only write back. After reset a clearing pass marks every site
// uninitialized, and requests wait in the queue until it ends.
`timescale 1ns / 1ps
module access_stride_classifier_top
    import asc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [9:0]  site_index,
    input  logic [31:0] iteration,
    input  logic [63:0] access_address,
    input  logic [7:0]  access_bytes,
    input  logic        is_write,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  pattern,
    output logic        pattern_changed,
    output logic [63:0] model_base,
    output logic signed [31:0] model_stride,
    output logic [31:0] model_base_iteration,
    output logic [31:0] prior_count,
    output logic [63:0] echoed_address,
    output logic        attribute_mismatch
);

    req_t in_req, q_req;
    res_t res;
    logic q_valid, q_ready;

    assign in_req.site      = SITE_W'(site_index % SITES);
    assign in_req.iteration = iteration;
    assign in_req.address   = access_address;
    assign in_req.nbytes    = access_bytes;
    assign in_req.wr        = is_write;

    asc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_req   (in_req),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_req    (q_req)
    );

    asc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_req     (q_req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (res)
    );

    assign pattern              = res.pattern;
    assign pattern_changed      = res.changed;
    assign model_base           = res.base;
    assign model_stride         = res.stride;
    assign model_base_iteration = res.biter;
    assign prior_count          = res.count;
    assign echoed_address       = res.address;
    assign attribute_mismatch   = res.mismatch;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(echoed_address))
        else $error("Result changed while stalled.");

    a_pattern_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pattern <= PAT_RANDOM)
        else $error("Result carries an uninitialized class.");

    a_first_const: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && prior_count == 32'd0 && pattern_changed |-> pattern == PAT_CONST)
        else $error("First access did not yield a constant class.");

endmodule

// ===== hdl/asc_divider.sv =====
// Radix-2 signed-by-unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module asc_divider
    import asc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] numer,
    input  logic [31:0] denom,
    output logic        done,
    output logic [31:0] quot
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [32:0] trial;
    logic [32:0] shifted;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        shifted   = {r_reg[31:0], q_reg[31]};
        trial     = shifted - {1'b0, d_reg};
        if (start)
        begin
            busy_next = 1'b1;
            neg_next  = numer[31];
            q_next    = numer[31] ? (32'd0 - numer) : numer;
            r_next    = '0;
            d_next    = denom;
            cnt_next  = 6'd32;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                r_next = trial;
                q_next = {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_next = shifted;
                q_next = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
    end

    assign done = done_reg;
    assign quot = neg_reg ? (32'd0 - q_reg) : q_reg;

endmodule

// ===== hdl/asc_front.sv =====
// Input queue between the request port and the table engine.
`timescale 1ns / 1ps
module asc_front
    import asc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  req_t  in_req,
    output logic  q_valid,
    input  logic  q_ready,
    output req_t  q_req
);

    req_t       mem [QDEPTH];
    logic [0:0] wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'(QDEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_req    = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= in_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== hdl/asc_back.sv =====
// Site table engine: clear at reset, then read, classify, divide or predict, write back, present result.
`timescale 1ns / 1ps
module asc_back
    import asc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  q_valid,
    output logic  q_ready,
    input  req_t  q_req,
    output logic  out_valid,
    input  logic  out_ready,
    output res_t  out_res
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam logic [2:0] ST_CLR  = 3'd5;

    typedef struct packed {
        logic [7:0]  nbytes;
        logic        wr;
        logic [63:0] base;
        logic [31:0] stride;
        logic [31:0] first;
        logic [31:0] count;
    } entry_t;

    entry_t     tbl [SITES];
    logic [1:0] cls_mem [SITES];
    logic [SITE_W-1:0] clr_reg;

    logic [2:0]  state_reg, state_next;
    req_t        req_reg;
    entry_t      ent_reg;
    logic [1:0]  cls_reg;
    logic [63:0] prod_reg;
    res_t        res_reg;
    logic        ovalid_reg;

    logic [1:0]  cls_now;
    logic [31:0] dlt;
    logic [63:0] sdiff;
    logic        div_start, div_done;
    logic [31:0] div_q;

    logic        wr_en;
    entry_t      wr_ent;
    logic [1:0]  wr_cls;
    logic [1:0]  ncls;
    logic [31:0] nstride;

    assign cls_now = cls_reg;
    assign dlt     = req_reg.iteration - ent_reg.first;
    assign sdiff   = req_reg.address - ent_reg.base;

    asc_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (sdiff[31:0]),
        .denom (dlt),
        .done  (div_done),
        .quot  (div_q)
    );

    always_comb
    begin
        ncls    = cls_now;
        nstride = ent_reg.stride;
        unique case (cls_now)
            CLS_UNINIT: ncls = CLS_CONST;
            CLS_CONST:
            begin
                nstride = 32'd0;
                if (req_reg.address != ent_reg.base)
                begin
                    if (ent_reg.count == 32'd1 && dlt != 32'd0)
                    begin
                        ncls    = CLS_LINEAR;
                        nstride = div_q;
                    end
                    else
                    begin
                        ncls = CLS_RANDOM;
                    end
                end
            end
            CLS_LINEAR:
            begin
                if (ent_reg.base + prod_reg != req_reg.address)
                begin
                    ncls = CLS_RANDOM;
                end
            end
            default: ncls = CLS_RANDOM;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        q_ready    = 1'b0;
        wr_en      = 1'b0;
        unique case (state_reg)
            ST_CLR:
            begin
                if (clr_reg == SITE_W'(SITES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (cls_now == CLS_CONST && req_reg.address != ent_reg.base
                    && ent_reg.count == 32'd1 && dlt != 32'd0)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else if (cls_now == CLS_LINEAR)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_MUL: state_next = ST_FIN;
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    wr_en      = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        wr_ent = ent_reg;
        wr_cls = ncls;
        if (cls_now == CLS_UNINIT)
        begin
            wr_ent.nbytes = req_reg.nbytes;
            wr_ent.wr     = req_reg.wr;
            wr_ent.base   = req_reg.address;
            wr_ent.stride = 32'd0;
            wr_ent.first  = req_reg.iteration;
            wr_ent.count  = 32'd1;
        end
        else
        begin
            wr_ent.stride = (cls_now == CLS_CONST) ? nstride : ent_reg.stride;
            if (ent_reg.count != 32'hFFFF_FFFF)
            begin
                wr_ent.count = ent_reg.count + 32'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid)
        begin
            req_reg <= q_req;
        end
        if (state_reg == ST_READ)
        begin
            prod_reg <= ({32'd0, dlt} * {32'd0, ent_reg.stride})
                        - (ent_reg.stride[31] ? {dlt, 32'd0} : 64'd0);
        end
        if (state_reg == ST_CLR)
        begin
            cls_mem[clr_reg] <= CLS_UNINIT;
        end
        if (wr_en)
        begin
            tbl[req_reg.site]     <= wr_ent;
            cls_mem[req_reg.site] <= wr_cls;
        end
        if (state_reg == ST_IDLE && q_valid)
        begin
            ent_reg <= tbl[q_req.site];
            cls_reg <= cls_mem[q_req.site];
        end
        if (wr_en)
        begin
            res_reg.pattern  <= ncls - 2'd1;
            res_reg.changed  <= (ncls != cls_now);
            res_reg.address  <= req_reg.address;
            if (cls_now == CLS_UNINIT)
            begin
                res_reg.base     <= 64'd0;
                res_reg.stride   <= 32'd0;
                res_reg.biter    <= req_reg.iteration;
                res_reg.count    <= 32'd0;
                res_reg.mismatch <= 1'b0;
            end
            else
            begin
                res_reg.base     <= (cls_now == CLS_RANDOM) ? 64'd0 : ent_reg.base;
                res_reg.stride   <= (cls_now == CLS_RANDOM) ? 32'd0 : nstride;
                res_reg.biter    <= ent_reg.first;
                res_reg.count    <= ent_reg.count;
                res_reg.mismatch <= (req_reg.nbytes != ent_reg.nbytes)
                                    || (req_reg.wr != ent_reg.wr);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLR;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (wr_en)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = ovalid_reg;
    assign out_res   = res_reg;

endmodule
